// ===== rtl/sspwm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sspwm_pkg: shared types and constants of the servo slew-limited PWM bank
// Field widths, reset values, compare scaling constants, transaction structs
// and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package sspwm_pkg;

  localparam int CHANNELS_DEF = 4;

  localparam int IDX_W   = 4;
  localparam int STEP_W  = 16;
  localparam int WIDTH_W = 15;
  localparam int CMP_W   = 14;

  localparam logic [WIDTH_W-1:0] WIDTH_FULL     = 15'd20000;
  localparam logic [WIDTH_W-1:0] INIT_RESET     = 15'd1500;
  localparam logic [STEP_W-1:0]  STEP_RESET     = 16'hFFFF;
  localparam logic [CMP_W-1:0]   COMPARE_PERIOD = 14'd9215;

  // position*9215 stays below 2^28; divide by 20000 via reciprocal + one fixup
  localparam int PROD_W      = 28;
  localparam int RECIP_SHIFT = 28;
  localparam int RECIP_W     = 14;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd20000);

  typedef enum logic {
    REQ_SET  = 1'b0,
    REQ_TICK = 1'b1
  } req_t;

  typedef enum logic {
    KIND_ACK    = 1'b0,
    KIND_UPDATE = 1'b1
  } kind_t;

  typedef enum logic {
    ST_OK        = 1'b0,
    ST_BAD_INDEX = 1'b1
  } status_t;

  typedef struct packed {
    req_t               req_type;
    logic [IDX_W-1:0]   servo_index;
    logic [STEP_W-1:0]  step_size;
    logic [WIDTH_W-1:0] target_width;
  } in_t;

  typedef struct packed {
    kind_t              result_kind;
    logic [IDX_W-1:0]   channel;
    logic [CMP_W-1:0]   compare_value;
    status_t            status;
    logic               last;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic cfg_we;
    logic cmd_acc;
    logic tick_acc;
    logic visit;
    logic mul;
    logic fix;
    logic flush;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic moving;
    logic ch_last;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/servo_slew_limited_pwm_bank.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// servo_slew_limited_pwm_bank: slew-rate limited servo PWM compare bank
// A bank of servo channels, each with a position, goal and slew step in
// microseconds. Commands set one channel's goal and step; ticks move every
// channel off its goal one step toward it and report its new compare value.
// ----------------------------------------------------------------------------
//
//  channel  | ports                          | handshake
//  ---------+--------------------------------+-------------------------------
//  request  | start, busy, in_data           | taken when start && !busy
//  result   | out_strobe, out_data           | one-cycle strobe, no backpressure
//  config   | cfg_valid, cfg_ready, cfg_data | written when valid && ready
//
// Timing: a command transaction is acknowledged on the result ports in the
//   following cycle and busy stays low, so commands may come every cycle.
// A tick walks the channels one at a time through the single slew/scaling
//   datapath: a channel at its goal is only visited, a moving one is visited
//   (step + multiply), then goes through the reciprocal multiply and the
//   quotient fixup, and a final flush releases the last update. Busy stays
//   high for the whole walk.
// Each update waits for the next one so the final one can carry last;
//   updates therefore come out strobed at irregular spacing within the walk.
// Reset (rst_n low, synchronous) loads every channel with 1500 and maximum
//   step. Config writes are taken only while idle with no request offered,
//   and reload every channel.
// The result side cannot stall; nothing here waits on it.
// ----------------------------------------------------------------------------
module servo_slew_limited_pwm_bank import sspwm_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // request transactions
  input  wire logic               start,
  output logic                    busy,
  input  wire in_t                in_data,
  // result transactions
  output logic                    out_strobe,
  output out_t                    out_data,
  // init_position register
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [WIDTH_W-1:0] cfg_data
);

  ctl_cmd_t ctl_cmd;
  dp_stat_t dp_stat;

  // sequencer: owns busy and cfg_ready, issues one command per cycle
  sspwm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .req_type  (in_data.req_type),
    .cfg_valid (cfg_valid),
    .stat      (dp_stat),
    .busy      (busy),
    .cfg_ready (cfg_ready),
    .cmd       (ctl_cmd)
  );

  // channel registers, slew step, compare scaling and output register
  sspwm_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (ctl_cmd),
    .in_data    (in_data),
    .cfg_data   (cfg_data),
    .stat       (dp_stat),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule
`default_nettype wire

// ===== rtl/sspwm_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sspwm_ctrl: sequencer of the servo PWM bank
// Accepts transactions, walks the channels on a tick and steps the
// compare-value pipeline for every channel that moves.
// ----------------------------------------------------------------------------
module sspwm_ctrl import sspwm_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire req_t     req_type,
  input  wire logic     cfg_valid,
  input  wire dp_stat_t stat,
  output logic          busy,
  output logic          cfg_ready,
  output ctl_cmd_t      cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_VISIT = 5'b00010,
    S_MUL   = 5'b00100,
    S_FIX   = 5'b01000,
    S_FLUSH = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  // a config write never shares an edge with a request transaction
  assign cfg_ready = !busy && !start;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.cfg_we   = cfg_valid && cfg_ready;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (req_type == REQ_TICK) begin
            cmd.tick_acc = 1'b1;
            state_nxt    = S_VISIT;
          end else begin
            cmd.cmd_acc = 1'b1;
          end
        end
      end
      S_VISIT: begin
        cmd.visit = 1'b1;
        if (stat.moving) begin
          state_nxt = S_MUL;
        end else if (stat.ch_last) begin
          state_nxt = S_FLUSH;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_FIX;
      end
      S_FIX: begin
        cmd.fix   = 1'b1;
        state_nxt = stat.ch_last ? S_FLUSH : S_VISIT;
      end
      S_FLUSH: begin
        cmd.flush = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/sspwm_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sspwm_dp: channel state and compare-value datapath
// Per-channel position/goal/step registers, the slew step, the scaling
// multiply/reciprocal-divide pipeline, a one-deep pending result and the
// output register.
// ----------------------------------------------------------------------------
module sspwm_dp import sspwm_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ctl_cmd_t           cmd,
  input  wire in_t                in_data,
  input  wire logic [WIDTH_W-1:0] cfg_data,
  output dp_stat_t                stat,
  output logic                    out_strobe,
  output out_t                    out_data
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [CH_W-1:0]  CH_LAST = CH_W'(CHANNELS - 1);
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(CHANNELS);

  function automatic logic [WIDTH_W-1:0] sat_width(input logic [WIDTH_W-1:0] v);
    sat_width = (v > WIDTH_FULL) ? WIDTH_FULL : v;
  endfunction

  logic [WIDTH_W-1:0] cur_r  [CHANNELS];
  logic [WIDTH_W-1:0] goal_r [CHANNELS];
  logic [STEP_W-1:0]  step_r [CHANNELS];
  logic [CH_W-1:0]    ch_r;
  logic [PROD_W-1:0]  prod_r;
  logic [CMP_W-1:0]   quot_r;
  logic               pend_v_r;
  logic [IDX_W-1:0]   pend_ch_r;
  logic [CMP_W-1:0]   pend_cmp_r;
  logic               out_strobe_r;
  out_t               out_r;

  // channel visit
  logic [WIDTH_W-1:0] cur_sel, goal_sel, pos_nxt;
  logic [STEP_W-1:0]  step_sel, gap;
  logic               going_up;
  logic [WIDTH_W+CMP_W-1:0] prod_full;

  always_comb begin
    cur_sel  = cur_r[ch_r];
    goal_sel = goal_r[ch_r];
    step_sel = step_r[ch_r];
    going_up = (cur_sel < goal_sel);
    gap      = going_up ? STEP_W'(goal_sel - cur_sel) : STEP_W'(cur_sel - goal_sel);
    if (gap <= step_sel) begin
      pos_nxt = goal_sel;
    end else if (going_up) begin
      pos_nxt = cur_sel + step_sel[WIDTH_W-1:0];
    end else begin
      pos_nxt = cur_sel - step_sel[WIDTH_W-1:0];
    end
    prod_full = pos_nxt * COMPARE_PERIOD;
  end

  assign stat.moving  = (cur_sel != goal_sel);
  assign stat.ch_last = (ch_r == CH_LAST);

  // quotient estimate is low by at most one; fix with one compare
  logic [PROD_W+RECIP_W-1:0] recip_full;
  logic [CMP_W+WIDTH_W-1:0]  back_full;
  logic [PROD_W-1:0]         rem;
  logic [CMP_W-1:0]          cmp_val;

  always_comb begin
    recip_full = prod_r * RECIP;
    back_full  = quot_r * WIDTH_FULL;
    rem        = prod_r - back_full[PROD_W-1:0];
    cmp_val    = quot_r + CMP_W'(rem >= PROD_W'(WIDTH_FULL));
  end

  // command decode
  logic [IDX_W-1:0] idx_m1;
  logic [CH_W-1:0]  waddr;
  logic             idx_ok;

  assign idx_ok = (in_data.servo_index != '0) && (in_data.servo_index <= IDX_MAX);
  assign idx_m1 = in_data.servo_index - IDX_W'(1);
  assign waddr  = idx_m1[CH_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        cur_r[i]  <= INIT_RESET;
        goal_r[i] <= INIT_RESET;
        step_r[i] <= STEP_RESET;
      end
    end else if (cmd.cfg_we) begin
      for (int i = 0; i < CHANNELS; i++) begin
        cur_r[i]  <= sat_width(cfg_data);
        goal_r[i] <= sat_width(cfg_data);
        step_r[i] <= STEP_RESET;
      end
    end else begin
      if (cmd.cmd_acc && idx_ok) begin
        goal_r[waddr] <= sat_width(in_data.target_width);
        step_r[waddr] <= in_data.step_size;
      end
      if (cmd.visit && stat.moving) begin
        cur_r[ch_r] <= pos_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r <= '0;
    end else if (cmd.tick_acc) begin
      ch_r <= '0;
    end else if ((cmd.visit && !stat.moving) || cmd.fix) begin
      ch_r <= ch_r + CH_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.visit) begin
      prod_r <= prod_full[PROD_W-1:0];
    end
    if (cmd.mul) begin
      quot_r <= recip_full[RECIP_SHIFT +: CMP_W];
    end
    if (cmd.fix) begin
      pend_ch_r  <= IDX_W'(ch_r) + IDX_W'(1);
      pend_cmp_r <= cmp_val;
    end
  end

  // pending update is released when the next mover or the end of the walk shows up
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      if (cmd.cmd_acc) begin
        out_strobe_r <= 1'b1;
      end else if (cmd.fix) begin
        out_strobe_r <= pend_v_r;
        pend_v_r     <= 1'b1;
      end else if (cmd.flush) begin
        out_strobe_r <= pend_v_r;
        pend_v_r     <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cmd_acc) begin
      out_r.result_kind   <= KIND_ACK;
      out_r.channel       <= in_data.servo_index;
      out_r.compare_value <= '0;
      out_r.status        <= idx_ok ? ST_OK : ST_BAD_INDEX;
      out_r.last          <= 1'b1;
    end else if (cmd.fix || cmd.flush) begin
      out_r.result_kind   <= KIND_UPDATE;
      out_r.channel       <= pend_ch_r;
      out_r.compare_value <= pend_cmp_r;
      out_r.status        <= ST_OK;
      out_r.last          <= cmd.flush;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_r;

endmodule
`default_nettype wire

// ===== rtl/sspwm_chk.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sspwm_chk: port-level checks of the servo PWM bank
// Acknowledge timing and content, update fields, tick and config interlock.
// ----------------------------------------------------------------------------
module sspwm_chk import sspwm_pkg::*; (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire in_t                in_data,
  input wire logic               out_strobe,
  input wire out_t               out_data,
  input wire logic               cfg_valid,
  input wire logic               cfg_ready
);

  logic cmd_taken, tick_taken;

  assign cmd_taken  = rst_n && start && !busy && (in_data.req_type == REQ_SET);
  assign tick_taken = rst_n && start && !busy && (in_data.req_type == REQ_TICK);

  a_ack_next: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_taken |=> out_strobe && (out_data.result_kind == KIND_ACK) && out_data.last &&
                  (out_data.compare_value == '0) &&
                  (out_data.channel == $past(in_data.servo_index)))
    else $error("command acknowledge missing or wrong");

  a_ack_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_data.result_kind == KIND_ACK) |-> $past(cmd_taken))
    else $error("acknowledge without a command transaction");

  a_update_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_data.result_kind == KIND_UPDATE) |->
      (out_data.status == ST_OK) && (out_data.channel != '0) &&
      (out_data.compare_value <= COMPARE_PERIOD))
    else $error("compare update fields out of range");

  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    tick_taken |=> busy)
    else $error("tick did not start a channel walk");

  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |-> !busy)
    else $error("config write taken while busy");

endmodule

bind servo_slew_limited_pwm_bank sspwm_chk u_sspwm_chk (.*);
`default_nettype wire

// ===== tb/tb_servo_slew_limited_pwm_bank.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_servo_slew_limited_pwm_bank: self-checking bench for the servo PWM bank
// Walks a short directed table (reset state, index errors, extreme widths,
// zero step, overshoot, saturated goals), then random command/tick traffic
// over several init_position settings. Every result transaction is checked
// field by field against an in-bench slew/compare predictor or typed row.
// ----------------------------------------------------------------------------
module tb_servo_slew_limited_pwm_bank import sspwm_pkg::*;;

  localparam int NCH = CHANNELS_DEF;
  localparam int unsigned FULL_US  = 20000;  // full-scale pulse width
  localparam int unsigned CMP_SPAN = 9215;   // compare count at full scale
  // Settle for longer than the worst tick walk, in which every channel moves.
  localparam int SETTLE_CYC = 3 * NCH + 8;
  localparam int PHASES     = 6;
  localparam int PHASE_LEN  = 80;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  in_t                 in_data;
  logic                out_strobe;
  out_t                out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [WIDTH_W-1:0]  cfg_data;

  servo_slew_limited_pwm_bank #(
    .CHANNELS (NCH)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor state: a private copy of the channel bank and init register.
  // --------------------------------------------------------------------------
  logic [WIDTH_W-1:0] init_w;
  logic [WIDTH_W-1:0] pos_w  [NCH];
  logic [WIDTH_W-1:0] goal_w [NCH];
  logic [STEP_W-1:0]  step_w [NCH];

  out_t pending_updates[$];  // expected result transactions, oldest first
  out_t slew_scratch[$];     // results of the transaction just predicted

  // Directed table, one row per transaction. Rows marked as typed carry
  // their expected result (zero or one) written out by hand.
  in_t  dir_item[$];
  bit   dir_typed[$];
  int   dir_n[$];
  out_t dir_res[$];

  // Hand-typed expectation for the transaction currently on the inputs.
  bit   typed_on;
  int   typed_n;
  out_t typed_res;

  int fail_cnt;
  int n_accepted;
  int n_ticks;
  int n_results;
  int n_cfg;

  function automatic out_t mk_res(input kind_t k, input logic [IDX_W-1:0] ch,
                                  input logic [CMP_W-1:0] cv, input status_t st,
                                  input logic l);
    out_t r;
    r.result_kind   = k;
    r.channel       = ch;
    r.compare_value = cv;
    r.status        = st;
    r.last          = l;
    return r;
  endfunction

  function automatic in_t mk_item(input req_t rq, input logic [IDX_W-1:0] idx,
                                  input logic [STEP_W-1:0] stp,
                                  input logic [WIDTH_W-1:0] tgt);
    in_t it;
    it.req_type     = rq;
    it.servo_index  = idx;
    it.step_size    = stp;
    it.target_width = tgt;
    return it;
  endfunction

  function automatic logic [WIDTH_W-1:0] clamp_width(input logic [WIDTH_W-1:0] v);
    return (v > FULL_US) ? WIDTH_W'(FULL_US) : v;
  endfunction

  // Init write: saturate, then reload every channel at full speed.
  function automatic void load_init(input logic [WIDTH_W-1:0] v);
    init_w = clamp_width(v);
    for (int i = 0; i < NCH; i++) begin
      pos_w[i]  = init_w;
      goal_w[i] = init_w;
      step_w[i] = '1;
    end
  endfunction

  // Slew/compare prediction for one accepted transaction; fills slew_scratch.
  function automatic void slew_predict(input in_t it);
    int unsigned cur;
    int unsigned goal;
    int unsigned stp;
    int unsigned cmp;
    int          slot;
    out_t        tail;
    slew_scratch.delete();
    if (it.req_type == REQ_SET) begin
      if (it.servo_index == 0 || it.servo_index > NCH) begin
        // bad index: no state change, error acknowledge only
        slew_scratch.push_back(mk_res(KIND_ACK, it.servo_index, '0, ST_BAD_INDEX, 1'b1));
      end else begin
        slot         = it.servo_index - 1;
        step_w[slot] = it.step_size;
        goal_w[slot] = clamp_width(it.target_width);
        slew_scratch.push_back(mk_res(KIND_ACK, it.servo_index, '0, ST_OK, 1'b1));
      end
    end else begin
      for (int i = 0; i < NCH; i++) begin
        cur  = pos_w[i];
        goal = goal_w[i];
        stp  = step_w[i];
        if (cur != goal) begin
          // wide arithmetic: a step past the goal lands on it
          if (cur < goal) cur = (goal - cur <= stp) ? goal : cur + stp;
          else            cur = (cur - goal <= stp) ? goal : cur - stp;
          pos_w[i] = cur[WIDTH_W-1:0];
          cmp = (cur * CMP_SPAN) / FULL_US;
          // zero step still reports, even without moving
          slew_scratch.push_back(mk_res(KIND_UPDATE, IDX_W'(i + 1), cmp[CMP_W-1:0],
                                        ST_OK, 1'b0));
        end
      end
      if (slew_scratch.size() != 0) begin
        tail      = slew_scratch.pop_back();
        tail.last = 1'b1;
        slew_scratch.push_back(tail);
      end
    end
  endfunction

  task automatic add_row(input in_t it, input bit typed, input int n, input out_t r);
    dir_item.push_back(it);
    dir_typed.push_back(typed);
    dir_n.push_back(n);
    dir_res.push_back(r);
  endtask

  // --------------------------------------------------------------------------
  // Monitor: everything is sampled at the rising edge, before the DUT's
  // nonblocking updates land. Results are checked first, then the accepted
  // request and config transactions are folded into the predictor.
  // --------------------------------------------------------------------------
  out_t want_r;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe === 1'b1) begin
        n_results++;
        if (pending_updates.size() == 0) begin
          $error("unexpected result: kind %0d channel %0d compare %0d status %0d last %0d",
                 out_data.result_kind, out_data.channel, out_data.compare_value,
                 out_data.status, out_data.last);
          fail_cnt++;
        end else begin
          want_r = pending_updates.pop_front();
          if (out_data.result_kind !== want_r.result_kind) begin
            $error("result_kind: expected %0d, got %0d", want_r.result_kind,
                   out_data.result_kind);
            fail_cnt++;
          end
          if (out_data.channel !== want_r.channel) begin
            $error("channel: expected %0d, got %0d", want_r.channel, out_data.channel);
            fail_cnt++;
          end
          if (out_data.compare_value !== want_r.compare_value) begin
            $error("compare_value: expected %0d, got %0d", want_r.compare_value,
                   out_data.compare_value);
            fail_cnt++;
          end
          if (out_data.status !== want_r.status) begin
            $error("status: expected %0d, got %0d", want_r.status, out_data.status);
            fail_cnt++;
          end
          if (out_data.last !== want_r.last) begin
            $error("last: expected %0d, got %0d", want_r.last, out_data.last);
            fail_cnt++;
          end
        end
      end

      if (start && !busy) begin
        n_accepted++;
        if (in_data.req_type == REQ_TICK) n_ticks++;
        slew_predict(in_data);
        if (typed_on) begin
          // hand-typed row: its expectation replaces the predicted one
          if (typed_n > 0) pending_updates.push_back(typed_res);
        end else begin
          foreach (slew_scratch[k]) pending_updates.push_back(slew_scratch[k]);
        end
      end

      if (cfg_valid && cfg_ready) begin
        n_cfg++;
        load_init(cfg_data);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks. Inputs move only at the falling edge.
  // --------------------------------------------------------------------------

  // Present one request transaction, hold until taken, then leave a `gap` idle.
  // With gap 0 start simply stays high into the next transaction.
  task automatic send_item(input in_t it, input bit typed, input int n,
                           input out_t r, input int gap);
    @(negedge clk);
    in_data   <= it;
    start     <= 1'b1;
    typed_on  = typed;
    typed_n   = n;
    typed_res = r;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Stop sending, wait for every expected result, then let an idle tick
  // (which gives no result) finish its channel walk.
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending_updates.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_init(input logic [WIDTH_W-1:0] v);
    drain_results();
    @(negedge clk);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed traffic: legal commands with in-range goals and steps
  // small enough to need several ticks, plenty of ticks, some bad indexes.
  function automatic in_t rand_item();
    in_t it;
    int  pick;
    int  sel;
    it.req_type    = REQ_SET;
    it.servo_index = IDX_W'($urandom_range(1, NCH));
    sel = $urandom_range(0, 7);
    case (sel)
      0:       it.step_size = STEP_W'($urandom_range(0, 3));
      1, 2, 3: it.step_size = STEP_W'($urandom_range(1, 500));
      4, 5:    it.step_size = STEP_W'($urandom_range(500, 8000));
      6:       it.step_size = STEP_W'($urandom_range(0, 65535));
      default: it.step_size = '1;
    endcase
    if ($urandom_range(0, 99) < 85) it.target_width = WIDTH_W'($urandom_range(0, FULL_US));
    else                            it.target_width = WIDTH_W'($urandom_range(FULL_US + 1, 32767));
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      // tick: the other fields are don't-care, so scramble them
      it.req_type     = REQ_TICK;
      it.servo_index  = IDX_W'($urandom_range(0, 15));
      it.step_size    = STEP_W'($urandom_range(0, 65535));
      it.target_width = WIDTH_W'($urandom_range(0, 32767));
    end else if (pick < 55) begin
      sel = $urandom_range(0, 15 - NCH);
      it.servo_index = (sel == 0) ? '0 : IDX_W'(NCH + sel);
    end
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  out_t none_r;
  in_t  rnd_it;
  int   gap;
  bit   burst;

  initial begin
    rst_n     = 1'b0;
    start     = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    typed_on  = 1'b0;
    typed_n   = 0;
    typed_res = '0;
    none_r    = '0;
    fail_cnt  = 0;
    n_accepted = 0;
    n_ticks    = 0;
    n_results  = 0;
    n_cfg      = 0;
    load_init(WIDTH_W'(1500));  // reset value of init_position

    // After reset everything sits at its goal: an idle tick, no results.
    add_row(mk_item(REQ_TICK, 4'd0, 16'h0000, 15'd0), 1'b1, 0, none_r);
    // Illegal indexes: zero, all ones, first past the bank.
    add_row(mk_item(REQ_SET, 4'd0, 16'hFFFF, 15'h7FFF), 1'b1, 1,
            mk_res(KIND_ACK, 4'd0, '0, ST_BAD_INDEX, 1'b1));
    add_row(mk_item(REQ_SET, 4'd15, 16'h0000, 15'd0), 1'b1, 1,
            mk_res(KIND_ACK, 4'd15, '0, ST_BAD_INDEX, 1'b1));
    add_row(mk_item(REQ_SET, IDX_W'(NCH + 1), 16'h0001, 15'd100), 1'b1, 1,
            mk_res(KIND_ACK, IDX_W'(NCH + 1), '0, ST_BAD_INDEX, 1'b1));
    // Full-scale goal at maximum speed: one tick reaches the top count.
    add_row(mk_item(REQ_SET, 4'd1, 16'hFFFF, 15'd20000), 1'b1, 1,
            mk_res(KIND_ACK, 4'd1, '0, ST_OK, 1'b1));
    add_row(mk_item(REQ_TICK, 4'd0, 16'h0000, 15'd0), 1'b1, 1,
            mk_res(KIND_UPDATE, 4'd1, 14'd9215, ST_OK, 1'b1));
    // Zero goal at maximum speed: compare count goes to zero.
    add_row(mk_item(REQ_SET, 4'd2, 16'hFFFF, 15'd0), 1'b1, 1,
            mk_res(KIND_ACK, 4'd2, '0, ST_OK, 1'b1));
    add_row(mk_item(REQ_TICK, 4'hF, 16'hFFFF, 15'h7FFF), 1'b1, 1,
            mk_res(KIND_UPDATE, 4'd2, 14'd0, ST_OK, 1'b1));
    // Zero step: channel reports every tick but never moves.
    add_row(mk_item(REQ_SET, 4'd3, 16'h0000, 15'd3000), 1'b0, 0, none_r);
    add_row(mk_item(REQ_TICK, 4'd0, 16'h0000, 15'd0), 1'b0, 0, none_r);
    // Goal above full scale saturates; small step crawls toward it.
    add_row(mk_item(REQ_SET, IDX_W'(NCH), 16'd7, 15'h7FFF), 1'b0, 0, none_r);
    // Step larger than the remaining distance lands on the goal.
    add_row(mk_item(REQ_SET, 4'd3, 16'd1000, 15'd2999), 1'b0, 0, none_r);
    add_row(mk_item(REQ_TICK, 4'd0, 16'h0000, 15'd0), 1'b0, 0, none_r);
    add_row(mk_item(REQ_TICK, 4'd0, 16'h0000, 15'd0), 1'b0, 0, none_r);
    // Several channels in motion at once: multi-result ticks.
    add_row(mk_item(REQ_SET, 4'd1, 16'd3, 15'd0), 1'b0, 0, none_r);
    add_row(mk_item(REQ_SET, 4'd2, 16'd5, 15'd20000), 1'b0, 0, none_r);
    add_row(mk_item(REQ_SET, 4'd3, 16'd12345, 15'd17), 1'b0, 0, none_r);
    add_row(mk_item(REQ_TICK, 4'd0, 16'h0000, 15'd0), 1'b0, 0, none_r);
    add_row(mk_item(REQ_TICK, 4'd0, 16'h0000, 15'd0), 1'b0, 0, none_r);
    add_row(mk_item(REQ_TICK, 4'd0, 16'h0000, 15'd0), 1'b0, 0, none_r);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_item[k]) begin
      send_item(dir_item[k], dir_typed[k], dir_n[k], dir_res[k], $urandom_range(0, 11));
    end

    // Random part: each phase starts with an init write while idle.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       write_init(WIDTH_W'($urandom_range(0, FULL_US)));
        1:       write_init(WIDTH_W'(FULL_US));
        2:       write_init('0);
        3:       write_init('1);  // saturates to full scale
        4:       write_init(WIDTH_W'($urandom_range(FULL_US + 1, 32767)));
        default: write_init(WIDTH_W'($urandom_range(0, FULL_US)));
      endcase
      for (int n = 0; n < PHASE_LEN; n++) begin
        // first stretch of each phase goes back to back
        burst = (n < 12);
        gap   = burst ? 0 : $urandom_range(0, 11);
        if (!burst && $urandom_range(0, 29) == 0) drain_results();
        rnd_it = rand_item();
        send_item(rnd_it, 1'b0, 0, none_r, gap);
      end
    end

    drain_results();

    $display("Run covered %0d request transactions (%0d ticks), %0d results checked,",
             n_accepted, n_ticks, n_results);
    $display("over %0d init_position writes plus the reset setting.", n_cfg);
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $error("timeout with %0d results still expected", pending_updates.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
